### hw/rtl/bdr_pkg.sv
// shared types and constants for the backlight duty ramp
package bdr_pkg;

    localparam int unsigned DUTY_W  = 7;
    localparam int unsigned STEP_W  = 8;
    localparam int unsigned WAIT_W  = 8;
    localparam int unsigned DIV_W   = 8;
    localparam int unsigned CFG_W   = 8;

    localparam logic [DUTY_W-1:0] DUTY_MAX        = 7'd100;
    localparam logic [DUTY_W-1:0] RAMP_STEPS_RST  = 7'd25;
    localparam logic [WAIT_W-1:0] WAIT_TICKS_RST  = 8'd20;

    // configuration register indexes
    localparam logic CFG_RAMP_STEPS = 1'b0;
    localparam logic CFG_WAIT_TICKS = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT   = 2'd0,
        OP_TARGET = 2'd1,
        OP_TICK   = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_ADJUSTING = 2'd1,
        PH_WAITING   = 2'd2,
        PH_ADJUSTED  = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        SQ_IDLE      = 2'd0,
        SQ_DIV_STEP  = 2'd1,
        SQ_DIV_LAST  = 2'd2,
        SQ_OUT       = 2'd3
    } t_seq;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIV_W-2:0]  divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [DIV_W-1:0]  quo;
        logic [DIV_W-2:0]  rem;
    } t_div_rsp;

endpackage

### hw/rtl/backlight_duty_ramp.sv
// backlight duty ramp: top level with sequencer, ramp state and shared divider
// init, tick, unused ops and a target equal to the duty: the sequencer goes from idle to
// SQ_OUT, which loads the result and returns to idle once the output is free.
// target with a change of duty: two passes of the shared divider (SQ_DIV_STEP, then
// SQ_DIV_LAST) before SQ_OUT; a held result adds its stall.
// synchronous active-low reset: duty 0, target 0, phase idle, ramp_steps 25, wait_ticks 20.
module backlight_duty_ramp
    import bdr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [6:0] duty_value
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] op
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [6:0] duty, [13:7] pwm_compare,
                                          // [14] busy_res, [15] ramp_done
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [CFG_W-1:0] i_cfg_wdata
);

    t_seq               r_seq, n_seq;
    t_phase             r_phase, n_phase;
    logic [DUTY_W-1:0]  r_cur, n_cur;
    logic [DUTY_W-1:0]  r_tgt, n_tgt;
    logic [STEP_W-1:0]  r_step, n_step;
    logic [STEP_W-1:0]  r_final, n_final;
    logic [WAIT_W-1:0]  r_wc, n_wc;
    logic [DUTY_W-1:0]  r_mag, n_mag;
    logic               r_done_pend, n_done_pend;
    logic [DUTY_W-1:0]  r_ramp_steps;
    logic [WAIT_W-1:0]  r_wait_ticks;
    logic               r_oval, n_oval;
    logic [15:0]        r_odata, n_odata;

    logic               accept;
    t_op                in_op;
    logic [DUTY_W-1:0]  in_duty;
    logic [DUTY_W-1:0]  span;
    logic               tgt_up;
    logic [STEP_W-1:0]  step_eff;
    logic [STEP_W-1:0]  move_amt;
    logic [DUTY_W-1:0]  move_clip;
    logic [DUTY_W-1:0]  moved;
    logic [WAIT_W-1:0]  wc_dec;
    logic [DUTY_W-1:0]  new_mag;
    logic [DUTY_W-1:0]  div_eff;
    logic               out_free;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    assign in_op   = t_op'(i_s_axis_tuser);
    assign in_duty = (i_s_axis_tdata[DUTY_W-1:0] > DUTY_MAX) ? DUTY_MAX
                                                            : i_s_axis_tdata[DUTY_W-1:0];
    assign o_s_axis_tready = (r_seq == SQ_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_oval || i_m_axis_tready;

    assign div_eff = (r_ramp_steps == '0) ? DUTY_W'(1) : r_ramp_steps;
    assign new_mag = (in_duty > r_cur) ? DUTY_W'(in_duty - r_cur) : DUTY_W'(r_cur - in_duty);

    // tick arithmetic: move toward the target, never past it
    assign tgt_up    = (r_tgt >= r_cur);
    assign span      = tgt_up ? DUTY_W'(r_tgt - r_cur) : DUTY_W'(r_cur - r_tgt);
    assign step_eff  = (r_step == '0) ? STEP_W'(1) : r_step;
    assign move_amt  = ({1'b0, span} < step_eff) ? r_final : step_eff;
    assign move_clip = (move_amt < {1'b0, span}) ? move_amt[DUTY_W-1:0] : span;
    assign moved     = tgt_up ? DUTY_W'(r_cur + move_clip) : DUTY_W'(r_cur - move_clip);
    assign wc_dec    = (r_wc != '0) ? WAIT_W'(r_wc - 1'b1) : '0;

    // divider requests: ceil(mag/div) first, then mag mod step
    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = DIV_W'({1'b0, new_mag} + {1'b0, div_eff} - 1'b1);
        div_req.divisor  = div_eff;
        if (accept && in_op == OP_TARGET && in_duty != r_cur) begin
            div_req.start = 1'b1;
        end else if (r_seq == SQ_DIV_STEP && div_rsp.done) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_W'(r_mag);
            div_req.divisor  = div_rsp.quo[DIV_W-2:0];
        end
    end

    bdr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // sequencer next state
    always_comb begin
        n_seq = r_seq;
        unique case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    n_seq = (in_op == OP_TARGET && in_duty != r_cur) ? SQ_DIV_STEP : SQ_OUT;
                end
            end
            SQ_DIV_STEP: begin
                if (div_rsp.done) begin
                    n_seq = SQ_DIV_LAST;
                end
            end
            SQ_DIV_LAST: begin
                if (div_rsp.done) begin
                    n_seq = SQ_OUT;
                end
            end
            SQ_OUT: begin
                if (out_free) begin
                    n_seq = SQ_IDLE;
                end
            end
            default: n_seq = SQ_IDLE;
        endcase
    end

    // ramp state and output register
    always_comb begin
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_step      = r_step;
        n_final     = r_final;
        n_wc        = r_wc;
        n_mag       = r_mag;
        n_done_pend = r_done_pend;
        n_oval      = r_oval;
        n_odata     = r_odata;
        if (r_oval && i_m_axis_tready) begin
            n_oval = 1'b0;
        end
        unique case (r_seq)
            SQ_IDLE: begin
                if (accept) begin
                    n_done_pend = 1'b0;
                    case (in_op)
                        OP_INIT: begin
                            n_cur   = in_duty;
                            n_tgt   = in_duty;
                            n_step  = '0;
                            n_phase = PH_IDLE;
                        end
                        OP_TARGET: begin
                            n_tgt = in_duty;
                            n_mag = new_mag;
                        end
                        OP_TICK: begin
                            case (r_phase)
                                PH_ADJUSTING: begin
                                    if (span == '0) begin
                                        n_phase = PH_ADJUSTED;
                                    end else if ({1'b0, span} < step_eff) begin
                                        n_cur   = moved;
                                        n_phase = PH_ADJUSTED;
                                    end else begin
                                        n_cur   = moved;
                                        n_wc    = r_wait_ticks;
                                        n_phase = PH_WAITING;
                                    end
                                end
                                PH_WAITING: begin
                                    n_wc = wc_dec;
                                    if (wc_dec == '0) begin
                                        n_phase = PH_ADJUSTING;
                                    end
                                end
                                PH_ADJUSTED: begin
                                    n_phase     = PH_IDLE;
                                    n_done_pend = 1'b1;
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            SQ_DIV_STEP: begin
                if (div_rsp.done) begin
                    n_step = div_rsp.quo;
                end
            end
            SQ_DIV_LAST: begin
                if (div_rsp.done) begin
                    n_final = (div_rsp.rem == '0) ? r_step : STEP_W'(div_rsp.rem);
                    n_phase = PH_ADJUSTING;
                end
            end
            SQ_OUT: begin
                if (out_free) begin
                    n_oval  = 1'b1;
                    n_odata = {r_done_pend, (r_phase != PH_IDLE),
                               DUTY_W'(DUTY_MAX - r_cur), r_cur};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq        <= SQ_IDLE;
            r_phase      <= PH_IDLE;
            r_cur        <= '0;
            r_tgt        <= '0;
            r_step       <= '0;
            r_final      <= '0;
            r_wc         <= '0;
            r_done_pend  <= 1'b0;
            r_oval       <= 1'b0;
            r_ramp_steps <= RAMP_STEPS_RST;
            r_wait_ticks <= WAIT_TICKS_RST;
        end else begin
            r_seq       <= n_seq;
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_tgt       <= n_tgt;
            r_step      <= n_step;
            r_final     <= n_final;
            r_wc        <= n_wc;
            r_done_pend <= n_done_pend;
            r_oval      <= n_oval;
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_RAMP_STEPS: r_ramp_steps <= i_cfg_wdata[DUTY_W-1:0];
                    CFG_WAIT_TICKS: r_wait_ticks <= i_cfg_wdata[WAIT_W-1:0];
                    default: ;
                endcase
            end
        end
        r_mag   <= n_mag;
        r_odata <= n_odata;
    end

    assign o_m_axis_tvalid = r_oval;
    assign o_m_axis_tdata  = r_odata;

endmodule

### hw/rtl/bdr_div.sv
// restoring divider, one quotient bit per cycle
module bdr_div
    import bdr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int unsigned CNT_W = $clog2(DIV_W);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [DIV_W-1:0]   r_quo, n_quo;
    logic [DIV_W-2:0]   r_rem, n_rem;
    logic [DIV_W-2:0]   r_dvs, n_dvs;
    logic [DIV_W-1:0]   trial;
    logic [DIV_W-1:0]   trial_sub;

    always_comb begin
        n_busy    = r_busy;
        n_done    = 1'b0;
        n_cnt     = r_cnt;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_dvs     = r_dvs;
        trial     = {r_rem, r_quo[DIV_W-1]};
        trial_sub = trial - {1'b0, r_dvs};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            // remainder stays below the divisor, so its top bit is always clear
            if (trial >= {1'b0, r_dvs}) begin
                n_rem = trial_sub[DIV_W-2:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b1};
            end else begin
                n_rem = trial[DIV_W-2:0];
                n_quo = {r_quo[DIV_W-2:0], 1'b0};
            end
            n_cnt = CNT_W'(r_cnt + 1'b1);
            if (r_cnt == CNT_W'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

### verif/testbench.sv
// self-checking stream testbench for the backlight duty ramp
`timescale 1ns / 1ps

module testbench
    import bdr_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 40;

    typedef struct packed {
        logic              done;
        logic              busy;
        logic [DUTY_W-1:0] pwm_cmp;
        logic [DUTY_W-1:0] duty;
    } t_duty_result;

    typedef struct packed {
        t_op               op;
        logic [DUTY_W-1:0] val;
        logic              typed;
        logic [DUTY_W-1:0] duty;
        logic              busy;
        logic              done;
    } t_plan_row;

    typedef struct packed {
        logic [DUTY_W-1:0] ramp_steps;
        logic [WAIT_W-1:0] wait_ticks;
        logic [15:0]       items;
    } t_setting;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_valid;
    logic              s_ready;
    logic [7:0]        s_data;
    logic [1:0]        s_user;
    logic              m_valid;
    logic              m_ready;
    logic [15:0]       m_data;
    logic              cfg_we;
    logic              cfg_addr;
    logic [CFG_W-1:0]  cfg_wdata;

    backlight_duty_ramp i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    // ramp state mirrored by the predictor
    logic [DUTY_W-1:0] cur_duty;
    logic [DUTY_W-1:0] tgt_duty;
    logic [STEP_W-1:0] step_mag;
    logic [STEP_W-1:0] last_mag;
    t_phase            ramp_phase;
    logic [WAIT_W-1:0] wait_left;
    logic [DUTY_W-1:0] cfg_ramp_steps;
    logic [WAIT_W-1:0] cfg_wait_ticks;

    t_duty_result      duty_results_due[$];
    int unsigned       mismatches = 0;
    int unsigned       cycle_count = 0;
    bit                calm;

    t_plan_row plan [0:24] = '{
        '{OP_TICK,   7'd0,   1'b1, 7'd0,   1'b0, 1'b0},
        '{OP_NONE,   7'd127, 1'b1, 7'd0,   1'b0, 1'b0},
        '{OP_INIT,   7'd100, 1'b1, 7'd100, 1'b0, 1'b0},
        '{OP_INIT,   7'd127, 1'b1, 7'd100, 1'b0, 1'b0},
        '{OP_TARGET, 7'd100, 1'b1, 7'd100, 1'b0, 1'b0},
        '{OP_INIT,   7'd0,   1'b1, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd100, 1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd127, 1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_NONE,   7'd55,  1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd127, 1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_INIT,   7'd50,  1'b1, 7'd50,  1'b0, 1'b0},
        '{OP_TARGET, 7'd60,  1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd50,  1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_INIT,   7'd0,   1'b1, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd1,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TICK,   7'd0,   1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_TARGET, 7'd85,  1'b0, 7'd0,   1'b0, 1'b0},
        '{OP_INIT,   7'd42,  1'b1, 7'd42,  1'b0, 1'b0}
    };

    // first entry runs on the reset values, no write
    t_setting settings [0:6] = '{
        '{7'd25,  8'd20,  16'd150},
        '{7'd1,   8'd0,   16'd150},
        '{7'd0,   8'd1,   16'd150},
        '{7'd127, 8'd3,   16'd150},
        '{7'd100, 8'd255, 16'd100},
        '{7'd2,   8'd2,   16'd200},
        '{7'd5,   8'd1,   16'd200}
    };

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic flag_mismatch(string what, int got, int want);
        $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
        mismatches++;
    endtask

    // moves the duty toward the target by at most amt
    function automatic void nudge_duty(int amt);
        int span;
        if (tgt_duty >= cur_duty) begin
            span = tgt_duty - cur_duty;
            cur_duty = DUTY_W'(cur_duty + ((amt < span) ? amt : span));
        end else begin
            span = cur_duty - tgt_duty;
            cur_duty = DUTY_W'(cur_duty - ((amt < span) ? amt : span));
        end
    endfunction

    function automatic t_duty_result next_duty_result(t_op op, logic [DUTY_W-1:0] raw);
        t_duty_result res;
        int v, mag, div, s, r, span;
        logic done;
        done = 1'b0;
        v = int'((raw > DUTY_MAX) ? DUTY_MAX : raw);
        case (op)
            OP_INIT: begin
                cur_duty = DUTY_W'(v);
                tgt_duty = DUTY_W'(v);
                step_mag = '0;
                ramp_phase = PH_IDLE;
            end
            OP_TARGET: begin
                tgt_duty = DUTY_W'(v);
                // no change of duty leaves the rest of the ramp alone
                if (v != cur_duty) begin
                    mag = (v > cur_duty) ? v - cur_duty : cur_duty - v;
                    div = (cfg_ramp_steps == 0) ? 1 : cfg_ramp_steps;
                    s = (mag <= div) ? 1 : (mag + div - 1) / div;
                    r = mag % s;
                    step_mag = STEP_W'(s);
                    last_mag = STEP_W'((r == 0) ? s : r);
                    ramp_phase = PH_ADJUSTING;
                end
            end
            OP_TICK: begin
                case (ramp_phase)
                    PH_ADJUSTING: begin
                        if (cur_duty == tgt_duty) begin
                            ramp_phase = PH_ADJUSTED;
                        end else begin
                            span = (tgt_duty > cur_duty) ? tgt_duty - cur_duty
                                                         : cur_duty - tgt_duty;
                            s = (step_mag == 0) ? 1 : step_mag;
                            if (span < s) begin
                                nudge_duty(last_mag);
                                ramp_phase = PH_ADJUSTED;
                            end else begin
                                nudge_duty(s);
                                wait_left = cfg_wait_ticks;
                                ramp_phase = PH_WAITING;
                            end
                        end
                    end
                    PH_WAITING: begin
                        if (wait_left != 0) wait_left = WAIT_W'(wait_left - 1'b1);
                        if (wait_left == 0) ramp_phase = PH_ADJUSTING;
                    end
                    PH_ADJUSTED: begin
                        ramp_phase = PH_IDLE;
                        done = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        res.duty = cur_duty;
        res.pwm_cmp = DUTY_MAX - cur_duty;
        res.busy = (ramp_phase != PH_IDLE);
        res.done = done;
        return res;
    endfunction

    task automatic send_request(t_op op, logic [DUTY_W-1:0] val, logic typed,
                                t_duty_result typed_res);
        t_duty_result predicted;
        int gap;
        gap = calm ? 0 : $urandom_range(0, 16);
        @(negedge i_clk);
        if (gap > 0) begin
            s_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data = {1'b0, val};
        s_user = op;
        do @(posedge i_clk); while (!s_ready);
        predicted = next_duty_result(op, val);
        duty_results_due.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_for_drain();
        while (duty_results_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(logic addr, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = data;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    task automatic check_result(logic [15:0] word);
        t_duty_result want;
        if (duty_results_due.size() == 0) begin
            flag_mismatch("result with nothing due, word", word, 0);
        end else begin
            want = duty_results_due.pop_front();
            if (word[6:0] !== want.duty)
                flag_mismatch("duty", word[6:0], want.duty);
            if (word[13:7] !== want.pwm_cmp)
                flag_mismatch("pwm_compare", word[13:7], want.pwm_cmp);
            if (word[14] !== want.busy)
                flag_mismatch("busy", word[14], want.busy);
            if (word[15] !== want.done)
                flag_mismatch("ramp_done", word[15], want.done);
        end
    endtask

    // result side: random stalls, then take one result
    initial begin
        int stall;
        m_ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 16);
            @(negedge i_clk);
            if (stall > 0) begin
                m_ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready = 1'b1;
            do @(posedge i_clk); while (!m_valid);
            check_result(m_data);
        end
    end

    initial begin
        t_duty_result typed_res;
        t_op op;
        logic [DUTY_W-1:0] val;
        int pick;
        calm = 1'b0;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = OP_TICK;
        cfg_we = 1'b0;
        cfg_addr = CFG_RAMP_STEPS;
        cfg_wdata = '0;
        cur_duty = '0;
        tgt_duty = '0;
        step_mag = '0;
        last_mag = '0;
        ramp_phase = PH_IDLE;
        wait_left = '0;
        cfg_ramp_steps = RAMP_STEPS_RST;
        cfg_wait_ticks = WAIT_TICKS_RST;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (plan[k]) begin
            typed_res.duty = plan[k].duty;
            typed_res.pwm_cmp = DUTY_MAX - plan[k].duty;
            typed_res.busy = plan[k].busy;
            typed_res.done = plan[k].done;
            send_request(plan[k].op, plan[k].val, plan[k].typed, typed_res);
        end

        foreach (settings[p]) begin
            if (p != 0) begin
                // sender holds off until the block has nothing in flight
                @(negedge i_clk);
                s_valid = 1'b0;
                wait_for_drain();
                write_register(CFG_RAMP_STEPS, {1'b0, settings[p].ramp_steps});
                write_register(CFG_WAIT_TICKS, settings[p].wait_ticks);
                cfg_ramp_steps = settings[p].ramp_steps;
                cfg_wait_ticks = settings[p].wait_ticks;
            end
            for (int n = 0; n < settings[p].items; n++) begin
                if (n % 50 == 0) calm = ($urandom_range(0, 3) == 0);
                // mostly ticks so that ramps run to the end
                pick = $urandom_range(0, 99);
                if (pick < 70) op = OP_TICK;
                else if (pick < 85) op = OP_TARGET;
                else if (pick < 95) op = OP_INIT;
                else op = OP_NONE;
                if ($urandom_range(0, 9) == 0) val = DUTY_W'($urandom_range(101, 127));
                else val = DUTY_W'($urandom_range(0, 100));
                send_request(op, val, 1'b0, '0);
            end
        end

        @(negedge i_clk);
        s_valid = 1'b0;
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/bdr_pkg.sv
hw/rtl/bdr_div.sv
hw/rtl/backlight_duty_ramp.sv
verif/testbench.sv
